[rtl/gfba_pkg.sv]
package gfba_pkg;

    localparam int BLK_W     = 10;
    localparam int WRD_W     = 5;
    localparam int REQ_W     = 2;
    localparam int CNT_W     = 7;
    localparam int ST_W      = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [REQ_W-1:0] REQ_FORMAT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DISK_BLOCKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WORDS = 2'd1;

    localparam logic [BLK_W-1:0] DISK_BLOCKS_RST = 10'd1023;
    localparam logic [WRD_W-1:0] BLOCK_WORDS_RST = 5'd16;
    localparam logic [WRD_W-1:0] MIN_WORDS       = 5'd3;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_NO_SPACE = 3'd1,
        ST_RANGE    = 3'd2,
        ST_FREE     = 3'd3,
        ST_LINK     = 3'd4
    } t_status;

    typedef struct packed {
        logic    acc;
        logic    fmt_init;
        logic    push;
        logic    spill;
        logic    fmt_next;
        logic    scan_start;
        logic    scan;
        logic    rd;
        logic    wchk;
        logic    pop;
        logic    lchk;
        logic    j_clr;
        logic    j_inc;
        logic    emit;
        t_status res_st;
        logic    res_grant;
        logic    res_last;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic req_fmt;
        logic req_alloc;
        logic req_free;
        logic rng_bad;
        logic alloc_big;
        logic cnt_zero;
        logic full;
        logic k_bw_last;
        logic blk_one;
        logic hit_sup;
        logic k_one;
        logic k_last;
        logic link_zero;
        logic k_zero;
        logic hit_disk;
        logic w_end;
        logic next_zero;
        logic n_lim;
        logic c_one;
        logic j_last;
        logic out_valid;
        logic out_taken;
        logic res_last;
    } t_sts;

endpackage

[rtl/gfba_datapath.sv]
module gfba_datapath #(
    parameter int MAX_DISK_BLOCKS = 1023,
    parameter int MAX_BLOCK_WORDS = 16,
    parameter int MAX_ALLOC       = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gfba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gfba_pkg::BLK_W-1:0]      i_cfg_data,
    input  logic [gfba_pkg::REQ_W-1:0]      i_req_type,
    input  logic [gfba_pkg::BLK_W-1:0]      i_block_number,
    input  logic [gfba_pkg::CNT_W-1:0]      i_count,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [gfba_pkg::ST_W-1:0]       o_status,
    output logic [gfba_pkg::BLK_W-1:0]      o_granted_block,
    output logic                            o_last,
    output logic [gfba_pkg::BLK_W-1:0]      o_free_count,
    output logic [gfba_pkg::BLK_W-1:0]      o_group_count,
    input  gfba_pkg::t_cmd                  i_cmd,
    output gfba_pkg::t_sts                  o_sts
);
    import gfba_pkg::*;

    localparam int IW    = $clog2(MAX_BLOCK_WORDS);
    localparam int DEPTH = (MAX_DISK_BLOCKS + 1) * MAX_BLOCK_WORDS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_DISK_BLOCKS + 1);

    logic [BLK_W-1:0] r_disk;
    logic [WRD_W-1:0] r_words;
    logic [REQ_W-1:0] r_req;
    logic [BLK_W-1:0] r_blk;
    logic [CNT_W-1:0] r_cnt_in;
    logic [BLK_W-1:0] r_cnt;
    logic [BLK_W-1:0] r_link;
    logic [BLK_W-1:0] r_sup [MAX_BLOCK_WORDS];
    logic [BLK_W-1:0] r_free;
    logic [BLK_W-1:0] r_grp;
    logic [IW-1:0]    r_k;
    logic [IW-1:0]    r_wc;
    logic [BLK_W-1:0] r_nlink;
    logic [BLK_W-1:0] r_cur;
    logic [NW-1:0]    r_n;
    logic [CNT_W-1:0] r_j;
    logic [BLK_W-1:0] r_grant;
    logic             r_gflag;
    t_status          r_res_st;
    logic             r_res_last;
    logic [BLK_W-1:0] r_mem [DEPTH];
    logic [BLK_W-1:0] r_q;
    logic             r_qok;
    logic             r_ov;
    t_status          r_ost;
    logic [BLK_W-1:0] r_ogr;
    logic             r_olast;
    logic [BLK_W-1:0] r_ofree;
    logic [BLK_W-1:0] r_ogrp;

    logic [BLK_W-1:0] disk_eff;
    logic [WRD_W-1:0] words_eff;
    logic [IW-1:0]    bwm1;
    logic [IW-1:0]    c;
    logic [IW-1:0]    sup_idx;
    logic [BLK_W-1:0] sup_rd;
    logic [BLK_W-1:0] scan_val;
    logic [BLK_W-1:0] spill_word;
    logic [BLK_W-1:0] q;
    logic [BLK_W-1:0] addr_blk;
    logic [AW-1:0]    mem_addr;
    logic             blk_ok;
    logic             mem_we;

    function automatic logic [IW-1:0] clamp_cnt(input logic [BLK_W-1:0] v,
                                                input logic [IW-1:0] top);
        logic [IW-1:0] res;
        if (v == '0) begin
            res = IW'(1);
        end else if (v > BLK_W'(top)) begin
            res = top;
        end else begin
            res = IW'(v);
        end
        return res;
    endfunction

    always_comb begin
        if (r_disk == '0) begin
            disk_eff = BLK_W'(1);
        end else if (32'(r_disk) > MAX_DISK_BLOCKS) begin
            disk_eff = BLK_W'(MAX_DISK_BLOCKS);
        end else begin
            disk_eff = r_disk;
        end
        if (r_words < MIN_WORDS) begin
            words_eff = MIN_WORDS;
        end else if (32'(r_words) > MAX_BLOCK_WORDS) begin
            words_eff = WRD_W'(MAX_BLOCK_WORDS);
        end else begin
            words_eff = r_words;
        end
    end

    assign bwm1       = IW'(words_eff - WRD_W'(1));
    assign c          = clamp_cnt(r_cnt, bwm1);
    assign sup_idx    = i_cmd.pop ? c : r_k;
    assign sup_rd     = r_sup[sup_idx];
    assign scan_val   = (r_k == IW'(1)) ? r_link : sup_rd;
    assign spill_word = (r_k == '0) ? BLK_W'(c) : scan_val;
    assign q          = r_qok ? r_q : '0;
    assign addr_blk   = i_cmd.spill ? r_blk : r_cur;
    assign blk_ok     = 32'(addr_blk) <= MAX_DISK_BLOCKS;
    assign mem_addr   = AW'(32'(addr_blk) * MAX_BLOCK_WORDS + 32'(r_k));
    assign mem_we     = i_cmd.spill && blk_ok;

    // disk store, single port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= spill_word;
        end
        if (i_cmd.rd) begin
            r_q   <= r_mem[mem_addr];
            r_qok <= blk_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (c < bwm1)) begin
            r_sup[IW'(c + IW'(1))] <= r_blk;
        end else if (i_cmd.lchk && (r_k > IW'(1))) begin
            r_sup[r_k] <= q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk  <= DISK_BLOCKS_RST;
            r_words <= BLOCK_WORDS_RST;
            r_cnt   <= BLK_W'(1);
            r_link  <= '0;
            r_free  <= '0;
            r_grp   <= BLK_W'(1);
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DISK_BLOCKS) begin
                    r_disk <= i_cfg_data;
                end else if (i_cfg_index == CFG_BLOCK_WORDS) begin
                    r_words <= i_cfg_data[WRD_W-1:0];
                end
            end
            if (i_cmd.acc) begin
                r_req    <= i_req_type;
                r_blk    <= i_block_number;
                r_cnt_in <= i_count;
            end
            if (i_cmd.fmt_init) begin
                r_cnt  <= BLK_W'(1);
                r_link <= '0;
                r_free <= '0;
                r_grp  <= BLK_W'(1);
                r_blk  <= disk_eff;
            end
            if (i_cmd.push) begin
                if (c < bwm1) begin
                    r_cnt <= BLK_W'(c + IW'(1));
                    if (r_free != '1) r_free <= r_free + 1'b1;
                end else begin
                    r_k <= '0;
                end
            end
            if (i_cmd.spill) begin
                r_k <= r_k + 1'b1;
                if (r_k == bwm1) begin
                    r_cnt  <= BLK_W'(1);
                    r_link <= r_blk;
                    if (r_grp != '1) r_grp <= r_grp + 1'b1;
                    if (r_free != '1) r_free <= r_free + 1'b1;
                end
            end
            if (i_cmd.fmt_next) begin
                r_blk <= r_blk - 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_k <= IW'(1);
            end
            if (i_cmd.scan) begin
                if (r_k == c) begin
                    r_cur <= r_link;
                    r_n   <= '0;
                    r_k   <= '0;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            if (i_cmd.wchk) begin
                if (r_k == '0) begin
                    r_wc <= clamp_cnt(q, bwm1);
                    r_k  <= IW'(1);
                end else begin
                    if (r_k == IW'(1)) r_nlink <= q;
                    if (r_k == r_wc) begin
                        r_cur <= (r_k == IW'(1)) ? q : r_nlink;
                        r_n   <= r_n + 1'b1;
                        r_k   <= '0;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
            end
            if (i_cmd.pop) begin
                if (c == IW'(1)) begin
                    r_cnt   <= BLK_W'(c);
                    r_grant <= r_link;
                    r_cur   <= r_link;
                    r_k     <= '0;
                end else begin
                    r_grant <= sup_rd;
                    r_cnt   <= BLK_W'(c - IW'(1));
                    if (r_free != '0) r_free <= r_free - 1'b1;
                end
            end
            if (i_cmd.lchk) begin
                if (r_k == '0) begin
                    r_cnt <= BLK_W'(clamp_cnt(q, bwm1));
                end else if (r_k == IW'(1)) begin
                    r_link <= q;
                end
                r_k <= r_k + 1'b1;
                if (r_k == bwm1) begin
                    if (r_grp > BLK_W'(1)) r_grp <= r_grp - 1'b1;
                    if (r_free != '0) r_free <= r_free - 1'b1;
                end
            end
            if (i_cmd.j_clr) begin
                r_j <= '0;
            end else if (i_cmd.j_inc) begin
                r_j <= r_j + 1'b1;
            end
            if (i_cmd.emit) begin
                r_res_st   <= i_cmd.res_st;
                r_gflag    <= i_cmd.res_grant;
                r_res_last <= i_cmd.res_last;
            end
            if (i_cmd.out_load) begin
                r_ov    <= 1'b1;
                r_ost   <= r_res_st;
                r_ogr   <= r_gflag ? r_grant : '0;
                r_olast <= r_res_last;
                r_ofree <= r_free;
                r_ogrp  <= r_grp;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.req_fmt   = r_req == REQ_FORMAT;
        o_sts.req_alloc = r_req == REQ_ALLOC;
        o_sts.req_free  = r_req == REQ_FREE;
        o_sts.rng_bad   = (r_blk == '0) || (r_blk > disk_eff);
        o_sts.alloc_big = (BLK_W'(r_cnt_in) > r_free) || (32'(r_cnt_in) > MAX_ALLOC);
        o_sts.cnt_zero  = r_cnt_in == '0;
        o_sts.full      = c >= bwm1;
        o_sts.k_bw_last = r_k == bwm1;
        o_sts.blk_one   = r_blk == BLK_W'(1);
        o_sts.hit_sup   = scan_val == r_blk;
        o_sts.k_one     = r_k == IW'(1);
        o_sts.k_last    = r_k == c;
        o_sts.link_zero = r_link == '0;
        o_sts.k_zero    = r_k == '0;
        o_sts.hit_disk  = q == r_blk;
        o_sts.w_end     = r_k == r_wc;
        o_sts.next_zero = ((r_k == IW'(1)) ? q : r_nlink) == '0;
        o_sts.n_lim     = 32'(r_n) >= MAX_DISK_BLOCKS;
        o_sts.c_one     = c == IW'(1);
        o_sts.j_last    = CNT_W'(r_j + 1'b1) == r_cnt_in;
        o_sts.out_valid = r_ov;
        o_sts.out_taken = r_ov && !i_stall;
        o_sts.res_last  = r_res_last;
    end

    assign o_valid         = r_ov;
    assign o_status        = r_ost;
    assign o_granted_block = r_ogr;
    assign o_last          = r_olast;
    assign o_free_count    = r_ofree;
    assign o_group_count   = r_ogrp;

    a_grp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grp != '0) else $error("group count reached zero");

    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != '0) else $error("table count reached zero");

    a_no_write_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !r_ov) else $error("disk write while a result is pending");

endmodule

[rtl/gfba_ctrl.sv]
module gfba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  gfba_pkg::t_sts i_sts,
    output gfba_pkg::t_cmd o_cmd
);
    import gfba_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_DEC   = 12'b0000_0000_0010,
        S_PUSH  = 12'b0000_0000_0100,
        S_SPILL = 12'b0000_0000_1000,
        S_SCAN  = 12'b0000_0001_0000,
        S_WREQ  = 12'b0000_0010_0000,
        S_WCHK  = 12'b0000_0100_0000,
        S_POP   = 12'b0000_1000_0000,
        S_LREQ  = 12'b0001_0000_0000,
        S_LCHK  = 12'b0010_0000_0000,
        S_EMIT  = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   push_done;

    assign o_stall = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd     = '0;
        o_cmd.res_st = ST_OK;
        n_state   = r_state;
        push_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.acc = 1'b1;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                priority if (i_sts.req_fmt) begin
                    o_cmd.fmt_init = 1'b1;
                    n_state        = S_PUSH;
                end else if (i_sts.req_free) begin
                    if (i_sts.rng_bad) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.res_st   = ST_RANGE;
                        o_cmd.res_last = 1'b1;
                        n_state        = S_EMIT;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end else if (i_sts.req_alloc) begin
                    priority if (i_sts.alloc_big) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.res_st   = ST_NO_SPACE;
                        o_cmd.res_last = 1'b1;
                        n_state        = S_EMIT;
                    end else if (i_sts.cnt_zero) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.res_last = 1'b1;
                        n_state        = S_EMIT;
                    end else begin
                        o_cmd.j_clr = 1'b1;
                        n_state     = S_POP;
                    end
                end else begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.res_st   = ST_RANGE;
                    o_cmd.res_last = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                if (i_sts.full) begin
                    n_state = S_SPILL;
                end else begin
                    push_done = 1'b1;
                end
            end
            S_SPILL: begin
                o_cmd.spill = 1'b1;
                if (i_sts.k_bw_last) begin
                    push_done = 1'b1;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                priority if (i_sts.hit_sup) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.res_st   = i_sts.k_one ? ST_LINK : ST_FREE;
                    o_cmd.res_last = 1'b1;
                    n_state        = S_EMIT;
                end else if (i_sts.k_last) begin
                    n_state = i_sts.link_zero ? S_PUSH : S_WREQ;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_WREQ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WCHK;
            end
            S_WCHK: begin
                o_cmd.wchk = 1'b1;
                priority if (!i_sts.k_zero && i_sts.hit_disk) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.res_st   = i_sts.k_one ? ST_LINK : ST_FREE;
                    o_cmd.res_last = 1'b1;
                    n_state        = S_EMIT;
                end else if (!i_sts.k_zero && i_sts.w_end
                             && (i_sts.next_zero || i_sts.n_lim)) begin
                    n_state = S_PUSH;
                end else begin
                    n_state = S_WREQ;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                priority if (i_sts.c_one && i_sts.link_zero) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.res_st   = ST_NO_SPACE;
                    o_cmd.res_last = 1'b1;
                    n_state        = S_EMIT;
                end else if (i_sts.c_one) begin
                    n_state = S_LREQ;
                end else begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.res_grant = 1'b1;
                    o_cmd.res_last  = i_sts.j_last;
                    n_state         = S_EMIT;
                end
            end
            S_LREQ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LCHK;
            end
            S_LCHK: begin
                o_cmd.lchk = 1'b1;
                if (i_sts.k_bw_last) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.res_grant = 1'b1;
                    o_cmd.res_last  = i_sts.j_last;
                    n_state         = S_EMIT;
                end else begin
                    n_state = S_LREQ;
                end
            end
            S_EMIT: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_taken) begin
                    if (i_sts.res_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.j_inc = 1'b1;
                        n_state     = S_POP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (push_done) begin
            if (i_sts.req_fmt && !i_sts.blk_one) begin
                o_cmd.fmt_next = 1'b1;
                n_state        = S_PUSH;
            end else begin
                o_cmd.emit     = 1'b1;
                o_cmd.res_last = 1'b1;
                n_state        = S_EMIT;
            end
        end
    end

    a_idle_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_sts.out_valid)
        else $error("result word pending while idle");

    a_out_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> i_sts.out_valid)
        else $error("waiting on a result word that is not there");

    a_emit_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |=> (r_state == S_OUT))
        else $error("result load not followed by hand-off");

endmodule

[rtl/grouped_free_block_allocator_unit.sv]
// grouped free-block allocator
// input channel: i_valid / o_stall with i_req_type, i_block_number, i_count;
// a word is taken at a clock edge with i_valid high and o_stall low
// output channel: o_valid / i_stall, one word per result; o_last marks the
// final word of a request
// config: i_cfg_we, i_cfg_index (0 disk blocks, 1 block words), i_cfg_data;
// write only while idle
// one request at a time; o_stall is high from acceptance until the last
// result word is taken
// steps: free of a bad block or an unknown request goes straight to the result
// word; allocate pops from the superblock and pulls in the next group table
// word by word from the disk store when only the link is left; free walks the
// superblock entry by entry and then each stored group word by word; format
// pushes every block and spills each full group to the disk store
// the disk store is single-port and its read is registered
// reset: empty list, one group, free count zero, registers 1023 and 16;
// the disk store holds no defined contents until a format or spill
// a stalled result word holds, and the block waits until it is taken
module grouped_free_block_allocator_unit #(
    parameter int MAX_DISK_BLOCKS = 1023,
    parameter int MAX_BLOCK_WORDS = 16,
    parameter int MAX_ALLOC       = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gfba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gfba_pkg::BLK_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [gfba_pkg::REQ_W-1:0]      i_req_type,
    input  logic [gfba_pkg::BLK_W-1:0]      i_block_number,
    input  logic [gfba_pkg::CNT_W-1:0]      i_count,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [gfba_pkg::ST_W-1:0]       o_status,
    output logic [gfba_pkg::BLK_W-1:0]      o_granted_block,
    output logic                            o_last,
    output logic [gfba_pkg::BLK_W-1:0]      o_free_count,
    output logic [gfba_pkg::BLK_W-1:0]      o_group_count
);
    import gfba_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gfba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gfba_datapath #(
        .MAX_DISK_BLOCKS (MAX_DISK_BLOCKS),
        .MAX_BLOCK_WORDS (MAX_BLOCK_WORDS),
        .MAX_ALLOC       (MAX_ALLOC)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_block_number  (i_block_number),
        .i_count         (i_count),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_granted_block (o_granted_block),
        .o_last          (o_last),
        .o_free_count    (o_free_count),
        .o_group_count   (o_group_count),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

[test/tb_grouped_free_block_allocator_unit.sv]
module tb_grouped_free_block_allocator_unit;
    import gfba_pkg::*;

    localparam logic [REQ_W-1:0]     REQ_UNKNOWN = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic [ST_W-1:0]  st;
        logic [BLK_W-1:0] gb;
        logic             last;
        logic [BLK_W-1:0] fc;
        logic [BLK_W-1:0] gc;
    } t_word;

    typedef struct {
        logic [REQ_W-1:0] req;
        logic [BLK_W-1:0] blk;
        logic [CNT_W-1:0] cnt;
        bit               typed;
        t_status          st;
        int               fc;
        int               gc;
    } t_row;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BLK_W-1:0]  i_cfg_data = '0;
    logic              i_valid = 0;
    logic              o_stall;
    logic [REQ_W-1:0]  i_req_type = '0;
    logic [BLK_W-1:0]  i_block_number = '0;
    logic [CNT_W-1:0]  i_count = '0;
    logic              o_valid;
    logic              i_stall = 0;
    logic [ST_W-1:0]   o_status;
    logic [BLK_W-1:0]  o_granted_block;
    logic              o_last;
    logic [BLK_W-1:0]  o_free_count;
    logic [BLK_W-1:0]  o_group_count;

    grouped_free_block_allocator_unit DUT (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [BLK_W-1:0] sup_tab [0:15];
    logic [BLK_W-1:0] disk_mem [0:1023][0:15];
    int unsigned      free_blks, grp_cnt, disk_reg, words_reg;

    t_word  grant_q[$];
    t_word  step_q[$];
    t_row   rows[$];
    int     errs = 0;
    int     n_items = 0, n_words = 0, n_phases = 0;
    int     tx_pct = 0, rx_pct = 0;

    function automatic int unsigned disk_lim();
        if (disk_reg < 1) return 1;
        if (disk_reg > 1023) return 1023;
        return disk_reg;
    endfunction

    function automatic int unsigned words_lim();
        if (words_reg < 3) return 3;
        if (words_reg > 16) return 16;
        return words_reg;
    endfunction

    function automatic int unsigned clamp_cnt(int unsigned c);
        if (c < 1) return 1;
        if (c > words_lim() - 1) return words_lim() - 1;
        return c;
    endfunction

    function automatic void push_blk(int unsigned b);
        int unsigned c = clamp_cnt(sup_tab[0]);
        int unsigned bw = words_lim();
        if (c < bw - 1) begin
            c++;
            sup_tab[0] = c;
            sup_tab[c] = b;
        end else begin
            sup_tab[0] = c;
            for (int i = 0; i < bw; i++) disk_mem[b][i] = sup_tab[i];
            foreach (sup_tab[i]) sup_tab[i] = '0;
            sup_tab[0] = 1;
            sup_tab[1] = b;
            if (grp_cnt < 1023) grp_cnt++;
        end
        if (free_blks < 1023) free_blks++;
    endfunction

    function automatic t_status find_blk(int unsigned b);
        int unsigned c, link, cur;
        c = clamp_cnt(sup_tab[0]);
        for (int k = 1; k <= c; k++)
            if (sup_tab[k] == b) return k == 1 ? ST_LINK : ST_FREE;
        link = sup_tab[1];
        for (int n = 0; link != 0 && n <= 1023; n++) begin
            cur = link;
            c = clamp_cnt(disk_mem[cur][0]);
            for (int k = 1; k <= c; k++)
                if (disk_mem[cur][k] == b) return k == 1 ? ST_LINK : ST_FREE;
            link = disk_mem[cur][1];
        end
        return ST_OK;
    endfunction

    function automatic void add_word(t_status st, int unsigned gb, bit last);
        t_word w;
        w.st = st;
        w.gb = gb;
        w.last = last;
        w.fc = free_blks;
        w.gc = grp_cnt;
        step_q.push_back(w);
    endfunction

    function automatic void predict_grants(logic [REQ_W-1:0] req, int unsigned blk,
                                           int unsigned cnt);
        int unsigned c, s, bw;
        t_status st;
        step_q.delete();
        if (req == REQ_FORMAT) begin
            foreach (sup_tab[i]) sup_tab[i] = '0;
            sup_tab[0] = 1;
            free_blks = 0;
            grp_cnt = 1;
            for (int i = disk_lim(); i >= 1; i--) push_blk(i);
            add_word(ST_OK, 0, 1);
        end else if (req == REQ_FREE) begin
            if (blk < 1 || blk > disk_lim()) add_word(ST_RANGE, 0, 1);
            else begin
                st = find_blk(blk);
                if (st == ST_OK) push_blk(blk);
                add_word(st, 0, 1);
            end
        end else if (req != REQ_ALLOC) begin
            add_word(ST_RANGE, 0, 1);
        end else if (cnt > free_blks || cnt > 64) begin
            add_word(ST_NO_SPACE, 0, 1);
        end else if (cnt == 0) begin
            add_word(ST_OK, 0, 1);
        end else begin
            bw = words_lim();
            for (int j = 0; j < cnt; j++) begin
                c = clamp_cnt(sup_tab[0]);
                sup_tab[0] = c;
                if (c == 1) begin
                    s = sup_tab[1];
                    if (s == 0) begin
                        add_word(ST_NO_SPACE, 0, 1);
                        return;
                    end
                    for (int i = 0; i < bw; i++) sup_tab[i] = disk_mem[s][i];
                    sup_tab[0] = clamp_cnt(sup_tab[0]);
                    if (grp_cnt > 1) grp_cnt--;
                end else begin
                    s = sup_tab[c];
                    sup_tab[0] = c - 1;
                end
                if (free_blks > 0) free_blks--;
                add_word(ST_OK, s, j + 1 == cnt);
            end
        end
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errs++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            n_words++;
            if (grant_q.size() == 0) report("unexpected word", 1, 0);
            else begin
                t_word w;
                w = grant_q.pop_front();
                if (o_status != w.st) report("status", o_status, w.st);
                if (o_granted_block != w.gb) report("granted_block", o_granted_block, w.gb);
                if (o_last != w.last) report("last", o_last, w.last);
                if (o_free_count != w.fc) report("free_count", o_free_count, w.fc);
                if (o_group_count != w.gc) report("group_count", o_group_count, w.gc);
            end
        end
    end

    always @(posedge i_clk) i_stall <= ($urandom_range(0, 99) < rx_pct);

    task automatic send(t_row r);
        t_word w;
        if ($urandom_range(0, 99) < tx_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < tx_pct) @(posedge i_clk);
        end
        i_valid <= 1;
        i_req_type <= r.req;
        i_block_number <= r.blk;
        i_count <= r.cnt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_items++;
        predict_grants(r.req, r.blk, r.cnt);
        if (r.typed) begin
            w.st = r.st;
            w.gb = 0;
            w.last = 1;
            w.fc = r.fc;
            w.gc = r.gc;
            grant_q.push_back(w);
        end else
            foreach (step_q[i]) grant_q.push_back(step_q[i]);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [BLK_W-1:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_DISK_BLOCKS) disk_reg = val;
        else if (idx == CFG_BLOCK_WORDS) words_reg = val & 31;
    endtask

    function automatic t_row mk(logic [REQ_W-1:0] req, int unsigned blk, int unsigned cnt);
        t_row r;
        r.req = req;
        r.blk = blk;
        r.cnt = cnt;
        r.typed = 0;
        r.st = ST_OK;
        r.fc = 0;
        r.gc = 0;
        return r;
    endfunction

    function automatic t_row mkt(logic [REQ_W-1:0] req, int unsigned blk, int unsigned cnt,
                                 t_status st, int fc, int gc);
        t_row r = mk(req, blk, cnt);
        r.typed = 1;
        r.st = st;
        r.fc = fc;
        r.gc = gc;
        return r;
    endfunction

    function automatic t_row rand_row();
        int unsigned p = $urandom_range(0, 99);
        int unsigned lim = disk_lim();
        if (p < 4) return mk(REQ_FORMAT, $urandom, $urandom);
        if (p < 7) return mk(REQ_UNKNOWN, $urandom, $urandom);
        if (p < 50) begin
            if ($urandom_range(0, 9) == 0) return mk(REQ_ALLOC, $urandom, $urandom);
            return mk(REQ_ALLOC, $urandom, $urandom_range(0, 8));
        end
        if ($urandom_range(0, 9) == 0) return mk(REQ_FREE, $urandom, $urandom);
        return mk(REQ_FREE, $urandom_range(0, lim + 1), $urandom);
    endfunction

    initial begin
        #50000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int disk_set [7] = '{1023, 20, 0, 40, 1, 100, 1023};
        int word_set [7] = '{16, 3, 31, 2, 17, 7, 3};
        int n_rand;
        foreach (sup_tab[i]) sup_tab[i] = '0;
        sup_tab[0] = 1;
        free_blks = 0;
        grp_cnt = 1;
        disk_reg = DISK_BLOCKS_RST;
        words_reg = BLOCK_WORDS_RST;

        // directed: reset state, range errors, format, extremes, link and last group
        rows.push_back(mkt(REQ_ALLOC, 0, 1, ST_NO_SPACE, 0, 1));
        rows.push_back(mkt(REQ_FREE, 0, 0, ST_RANGE, 0, 1));
        rows.push_back(mkt(REQ_UNKNOWN, 1023, 127, ST_RANGE, 0, 1));
        rows.push_back(mkt(REQ_FREE, 1023, 0, ST_OK, 1, 1));
        rows.push_back(mkt(REQ_FREE, 1023, 0, ST_FREE, 1, 1));
        rows.push_back(mkt(REQ_ALLOC, 0, 0, ST_OK, 1, 1));
        rows.push_back(mkt(REQ_ALLOC, 0, 2, ST_NO_SPACE, 1, 1));
        rows.push_back(mk(REQ_FORMAT, 0, 0));
        rows.push_back(mk(REQ_FREE, 1009, 0));
        rows.push_back(mk(REQ_FREE, 1010, 0));
        rows.push_back(mk(REQ_FREE, 1, 0));
        rows.push_back(mk(REQ_ALLOC, 1023, 65));
        rows.push_back(mk(REQ_ALLOC, 0, 127));
        rows.push_back(mk(REQ_ALLOC, 0, 64));
        rows.push_back(mk(REQ_ALLOC, 0, 15));
        rows.push_back(mk(REQ_FREE, 1000, 0));
        rows.push_back(mk(REQ_FREE, 1023, 0));
        rows.push_back(mk(REQ_FREE, 960, 0));
        rows.push_back(mk(REQ_ALLOC, 0, 0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (rows[i]) send(rows[i]);
        drain();

        n_rand = 0;
        for (int ph = 0; ph < 7; ph++) begin
            n_phases++;
            if (ph == 2) cfg_write(CFG_SPARE_A, 10'd5);
            if (ph == 4) cfg_write(CFG_SPARE_B, 10'd1023);
            cfg_write(CFG_DISK_BLOCKS, disk_set[ph]);
            cfg_write(CFG_BLOCK_WORDS, word_set[ph]);
            // store contents follow the word count, so rebuild after every change
            send(mk(REQ_FORMAT, $urandom, $urandom));
            for (int k = 0; k < 40; k++) begin
                if (n_rand < 95) begin
                    tx_pct = 25;
                    rx_pct = 49;
                end else if (n_rand < 190) begin
                    tx_pct = 49;
                    rx_pct = 25;
                end else begin
                    tx_pct = 0;
                    rx_pct = 0;
                end
                if (n_rand == 140) begin
                    i_valid <= 0;
                    @(posedge i_clk);
                    while (grant_q.size() != 0) @(posedge i_clk);
                end
                send(rand_row());
                n_rand++;
            end
            drain();
        end

        $display("covered %0d requests and %0d result words over %0d settings",
                 n_items, n_words, n_phases + 1);
        $display("disk sizes 1 to 1023, block words 3 to 16, with idle and stall mixes");
        if (errs == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
